// File: hdl/qccc_pkg.sv
package qccc_pkg;

  localparam int CHIPS_PER_SECTION = 8;
  localparam int SECTION_COUNT     = 16;
  localparam int CODE_LEN          = CHIPS_PER_SECTION * SECTION_COUNT;
  localparam int LINE_LEN          = 2 * CODE_LEN;
  localparam int NUM_LINES         = 4;
  localparam int SCORE_W           = $clog2(CHIPS_PER_SECTION + 1) + 1;
  localparam int BIN_W             = $clog2(SECTION_COUNT);
  localparam int SUM_W             = SCORE_W + 2;
  localparam int DATA_W            = 16;

  localparam logic signed [31:0] SAT_HI = (1 <<< 15) - 1;
  localparam logic signed [31:0] SAT_LO = -(1 <<< 15);

  // line order inside a score set
  localparam int LINE_NI = 0;
  localparam int LINE_NQ = 1;
  localparam int LINE_PI = 2;
  localparam int LINE_PQ = 3;

  localparam logic [1:0] MODE_SINGLE = 2'd0;
  localparam logic [1:0] MODE_PAIR   = 2'd1;
  localparam logic [1:0] MODE_QUAD   = 2'd2;
  localparam logic [1:0] MODE_QUAD_B = 2'd3;

  typedef logic signed [SCORE_W-1:0] score_t;
  typedef score_t [NUM_LINES-1:0][SECTION_COUNT-1:0] score_set_t;

endpackage

// File: hdl/qccc_front.sv
module qccc_front import qccc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic       code_valid,
  input  logic       code_bit,
  input  logic       code_last,
  input  logic       sample_valid,
  input  logic       bit_n_inphase,
  input  logic       bit_n_quadrature,
  input  logic       bit_p_inphase,
  input  logic       bit_p_quadrature,
  output logic       push,
  output score_set_t scores
);

  logic [CODE_LEN-1:0]                 code_reg, code_reg_next;
  logic [CODE_LEN-1:0]                 snap, snap_next;
  logic [NUM_LINES-1:0][LINE_LEN-1:0]  lines, lines_next;
  logic [NUM_LINES-1:0]                new_bits;

  assign new_bits = {bit_p_quadrature, bit_p_inphase, bit_n_quadrature, bit_n_inphase};

  always_comb begin
    code_reg_next = code_reg;
    if (code_valid) begin
      code_reg_next = {code_bit, code_reg[CODE_LEN-1:1]};
    end
    snap_next = code_last ? code_reg_next : snap;
    for (int l = 0; l < NUM_LINES; l++) begin
      lines_next[l] = sample_valid ? {new_bits[l], lines[l][LINE_LEN-1:1]} : lines[l];
    end
  end

  // per-section scores over the updated lines and snapshot
  always_comb begin
    logic a, b, c;
    score_t acc;
    for (int l = 0; l < NUM_LINES; l++) begin
      for (int s = 0; s < SECTION_COUNT; s++) begin
        acc = '0;
        for (int i = 0; i < CHIPS_PER_SECTION; i++) begin
          a = lines_next[l][s*2*CHIPS_PER_SECTION + 2*i];
          b = lines_next[l][s*2*CHIPS_PER_SECTION + 2*i + 1];
          c = snap_next[s*CHIPS_PER_SECTION + i];
          if (a == b) begin
            acc = (a == c) ? score_t'(acc + score_t'(1)) : score_t'(acc - score_t'(1));
          end
        end
        scores[l][s] = acc;
      end
    end
  end

  assign push = accept && sample_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      code_reg <= '0;
      snap     <= '0;
      lines    <= '0;
    end else if (accept) begin
      code_reg <= code_reg_next;
      snap     <= snap_next;
      lines    <= lines_next;
    end
  end

endmodule

// File: hdl/qccc_queue.sv
module qccc_queue import qccc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  score_set_t push_data,
  input  logic       pop,
  output logic       full,
  output logic       head_valid,
  output score_set_t head
);

  score_set_t  entries [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;

  assign full       = (count == 2'd2);
  assign head_valid = (count != 2'd0);
  assign head       = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

// File: hdl/qccc_back.sv
module qccc_back import qccc_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_write,
  input  logic [1:0]               cfg_data,
  input  logic                     head_valid,
  input  score_set_t               head,
  output logic                     pop,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic                     frame_kind,
  output logic [BIN_W-1:0]         bin_index,
  output logic signed [DATA_W-1:0] real_part,
  output logic signed [DATA_W-1:0] imag_part,
  output logic                     frame_end,
  output logic                     run_end
);

  logic [1:0]              group_mode;
  logic                    frame;
  logic [BIN_W-1:0]        bin;
  logic [1:0]              shift;
  logic [2:0]              group;
  logic [BIN_W-1:0]        last_bin;
  logic                    load;
  logic                    is_last_bin;
  logic signed [SUM_W-1:0] sum_re, sum_im;
  logic [BIN_W-1:0]        idx;

  function automatic logic signed [DATA_W-1:0] sat16(input logic signed [SUM_W-1:0] v);
    logic signed [31:0] w;
    w = 32'(v);
    if (w > SAT_HI) begin
      return DATA_W'(SAT_HI);
    end else if (w < SAT_LO) begin
      return DATA_W'(SAT_LO);
    end
    return w[DATA_W-1:0];
  endfunction

  always_comb begin
    case (group_mode)
      MODE_SINGLE: shift = 2'd0;
      MODE_PAIR:   shift = 2'd1;
      MODE_QUAD, MODE_QUAD_B: shift = 2'd2;
      default:     shift = 2'd2;
    endcase
    group    = 3'(1 << shift);
    last_bin = BIN_W'((SECTION_COUNT >> shift) - 1);
  end

  always_comb begin
    sum_re = '0;
    sum_im = '0;
    for (int k = 0; k < 4; k++) begin
      idx = BIN_W'((bin << shift) + BIN_W'(k));
      if (3'(k) < group) begin
        sum_re = sum_re + SUM_W'(head[frame ? LINE_PI : LINE_NI][idx]);
        sum_im = sum_im + SUM_W'(head[frame ? LINE_PQ : LINE_NQ][idx]);
      end
    end
  end

  assign is_last_bin = (bin == last_bin);
  assign load        = head_valid && (!out_valid || !out_stall);
  assign pop         = load && frame && is_last_bin;

  always_ff @(posedge clk) begin
    if (rst) begin
      group_mode <= MODE_SINGLE;
      frame      <= 1'b0;
      bin        <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_write) begin
        group_mode <= cfg_data;
      end
      if (load) begin
        out_valid <= 1'b1;
        if (is_last_bin) begin
          bin   <= '0;
          frame <= ~frame;
        end else begin
          bin <= bin + 1'b1;
        end
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      frame_kind <= frame;
      bin_index  <= bin;
      real_part  <= sat16(sum_re);
      imag_part  <= sat16(sum_im);
      frame_end  <= is_last_bin;
      run_end    <= frame && is_last_bin;
    end
  end

endmodule

// File: hdl/quad_channel_code_correlator.sv
// An accepted sample item's scores enter the score queue; the back end registers each result.
// Throughput: one result per cycle while out_stall is low; a sample item gives 32, 16 or 8 results
// (mode 0, 1, 2/3), set by the back end's single bin sequencer. Code-only items are not queued.
// A two-entry score queue lets the front take items while the back still emits.
// Reset (rst, synchronous): clears code register, snapshot, sample lines, mode, queue and bin sequencer.
module quad_channel_code_correlator import qccc_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [1:0]               cfg_data,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     code_valid,
  input  logic                     code_bit,
  input  logic                     code_last,
  input  logic                     sample_valid,
  input  logic                     bit_n_inphase,
  input  logic                     bit_n_quadrature,
  input  logic                     bit_p_inphase,
  input  logic                     bit_p_quadrature,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic                     frame_kind,
  output logic [BIN_W-1:0]         bin_index,
  output logic signed [DATA_W-1:0] real_part,
  output logic signed [DATA_W-1:0] imag_part,
  output logic                     frame_end,
  output logic                     run_end
);

  logic       accept;
  logic       push;
  logic       pop;
  logic       full;
  logic       head_valid;
  score_set_t scores;
  score_set_t head;

  assign cfg_ready = 1'b1;
  assign in_stall  = full;
  assign accept    = in_valid && !in_stall;

  qccc_front u_front (
    .clk              (clk),
    .rst              (rst),
    .accept           (accept),
    .code_valid       (code_valid),
    .code_bit         (code_bit),
    .code_last        (code_last),
    .sample_valid     (sample_valid),
    .bit_n_inphase    (bit_n_inphase),
    .bit_n_quadrature (bit_n_quadrature),
    .bit_p_inphase    (bit_p_inphase),
    .bit_p_quadrature (bit_p_quadrature),
    .push             (push),
    .scores           (scores)
  );

  qccc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (scores),
    .pop        (pop),
    .full       (full),
    .head_valid (head_valid),
    .head       (head)
  );

  qccc_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_valid && cfg_ready),
    .cfg_data   (cfg_data),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .frame_kind (frame_kind),
    .bin_index  (bin_index),
    .real_part  (real_part),
    .imag_part  (imag_part),
    .frame_end  (frame_end),
    .run_end    (run_end)
  );

endmodule

// File: tb/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import qccc_pkg::*;

  localparam int HOLD_CYCLES  = 300;
  localparam int STALL_LIMIT  = 2000;
  localparam int SETTLE       = 4;
  localparam int MATCH_LEN    = 96;
  localparam int PRINT_CAP    = 40;

  typedef struct {
    logic                 code_valid;
    logic                 code_bit;
    logic                 code_last;
    logic                 sample_valid;
    logic [NUM_LINES-1:0] smp;
  } corr_item_t;

  typedef struct {
    logic                     frame_kind;
    logic [BIN_W-1:0]         bin_index;
    logic signed [DATA_W-1:0] real_part;
    logic signed [DATA_W-1:0] imag_part;
    logic                     frame_end;
    logic                     run_end;
  } bin_result_t;

  class corr_scoreboard;
    bit [1:0]          group_mode;
    bit [CODE_LEN-1:0] code_shift;
    bit [CODE_LEN-1:0] code_active;
    bit [LINE_LEN-1:0] sample_lines [NUM_LINES];
    bin_result_t       expected_bins [$];
    int                mismatches;
    int                checked;

    function new();
      group_mode  = MODE_SINGLE;
      code_shift  = '0;
      code_active = '0;
      foreach (sample_lines[i]) sample_lines[i] = '0;
      mismatches  = 0;
      checked     = 0;
    endfunction

    function int section_score(int ln, int sec);
      int acc = 0;
      bit a, b, c;
      for (int i = 0; i < CHIPS_PER_SECTION; i++) begin
        a = sample_lines[ln][sec*2*CHIPS_PER_SECTION + 2*i];
        b = sample_lines[ln][sec*2*CHIPS_PER_SECTION + 2*i + 1];
        c = code_active[sec*CHIPS_PER_SECTION + i];
        if (a == b) acc += (a == c) ? 1 : -1;
      end
      return acc;
    endfunction

    function logic signed [DATA_W-1:0] clamp16(int v);
      if (v > SAT_HI) return SAT_HI[DATA_W-1:0];
      if (v < SAT_LO) return SAT_LO[DATA_W-1:0];
      return v[DATA_W-1:0];
    endfunction

    function void correlate_item(corr_item_t it);
      int sc [NUM_LINES][SECTION_COUNT];
      int grp, nbins, total, n, re_sum, im_sum, re_ln, im_ln;
      bin_result_t r;
      if (it.code_valid) code_shift = {it.code_bit, code_shift[CODE_LEN-1:1]};
      if (it.code_last) code_active = code_shift;
      if (!it.sample_valid) return;
      for (int ln = 0; ln < NUM_LINES; ln++)
        sample_lines[ln] = {it.smp[ln], sample_lines[ln][LINE_LEN-1:1]};
      for (int ln = 0; ln < NUM_LINES; ln++)
        for (int s = 0; s < SECTION_COUNT; s++)
          sc[ln][s] = section_score(ln, s);
      grp   = (group_mode == MODE_SINGLE) ? 1 : (group_mode == MODE_PAIR) ? 2 : 4;
      nbins = SECTION_COUNT / grp;
      total = 2 * nbins;
      n     = 0;
      for (int f = 0; f < 2; f++) begin
        re_ln = f ? LINE_PI : LINE_NI;
        im_ln = f ? LINE_PQ : LINE_NQ;
        for (int b = 0; b < nbins; b++) begin
          re_sum = 0;
          im_sum = 0;
          for (int k = 0; k < grp; k++) begin
            re_sum += sc[re_ln][b*grp + k];
            im_sum += sc[im_ln][b*grp + k];
          end
          r.frame_kind = (f != 0);
          r.bin_index  = BIN_W'(b);
          r.real_part  = clamp16(re_sum);
          r.imag_part  = clamp16(im_sum);
          r.frame_end  = (b == nbins - 1);
          r.run_end    = (n == total - 1);
          expected_bins.push_back(r);
          n++;
        end
      end
    endfunction

    task report(string msg);
      mismatches++;
      if (mismatches <= PRINT_CAP) $display("ERROR @%0t: %s", $time, msg);
    endtask

    task check_bin(bin_result_t got);
      bin_result_t want;
      string tag;
      if (expected_bins.size() == 0) begin
        report($sformatf("unexpected bin: frame=%0d bin=%0d re=%0d im=%0d",
                         got.frame_kind, got.bin_index, got.real_part, got.imag_part));
        return;
      end
      want = expected_bins.pop_front();
      checked++;
      tag = $sformatf("frame %0d bin %0d:", want.frame_kind, want.bin_index);
      if (got.frame_kind !== want.frame_kind)
        report($sformatf("%s frame_kind %0d want %0d", tag, got.frame_kind, want.frame_kind));
      if (got.bin_index !== want.bin_index)
        report($sformatf("%s bin_index %0d want %0d", tag, got.bin_index, want.bin_index));
      if (got.real_part !== want.real_part)
        report($sformatf("%s real_part %0d want %0d", tag, got.real_part, want.real_part));
      if (got.imag_part !== want.imag_part)
        report($sformatf("%s imag_part %0d want %0d", tag, got.imag_part, want.imag_part));
      if (got.frame_end !== want.frame_end)
        report($sformatf("%s frame_end %0d want %0d", tag, got.frame_end, want.frame_end));
      if (got.run_end !== want.run_end)
        report($sformatf("%s run_end %0d want %0d", tag, got.run_end, want.run_end));
    endtask
  endclass

  logic                     clk;
  logic                     rst;
  logic                     cfg_valid;
  logic                     cfg_ready;
  logic [1:0]               cfg_data;
  logic                     in_valid;
  logic                     in_stall;
  logic                     code_valid;
  logic                     code_bit;
  logic                     code_last;
  logic                     sample_valid;
  logic                     bit_n_inphase;
  logic                     bit_n_quadrature;
  logic                     bit_p_inphase;
  logic                     bit_p_quadrature;
  logic                     out_valid;
  logic                     out_stall;
  logic                     frame_kind;
  logic [BIN_W-1:0]         bin_index;
  logic signed [DATA_W-1:0] real_part;
  logic signed [DATA_W-1:0] imag_part;
  logic                     frame_end;
  logic                     run_end;

  corr_scoreboard sb;
  bit steady;
  bit hold_req;
  bit hold_done;
  int n_items;
  int n_samples;
  int n_cfg;

  quad_channel_code_correlator uut (
    .clk              (clk),
    .rst              (rst),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .code_valid       (code_valid),
    .code_bit         (code_bit),
    .code_last        (code_last),
    .sample_valid     (sample_valid),
    .bit_n_inphase    (bit_n_inphase),
    .bit_n_quadrature (bit_n_quadrature),
    .bit_p_inphase    (bit_p_inphase),
    .bit_p_quadrature (bit_p_quadrature),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .frame_kind       (frame_kind),
    .bin_index        (bin_index),
    .real_part        (real_part),
    .imag_part        (imag_part),
    .frame_end        (frame_end),
    .run_end          (run_end)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic corr_item_t mk(bit cv, bit cb, bit cl, bit sv, bit [NUM_LINES-1:0] smp);
    corr_item_t it;
    it.code_valid   = cv;
    it.code_bit     = cb;
    it.code_last    = cl;
    it.sample_valid = sv;
    it.smp          = smp;
    return it;
  endfunction

  function automatic corr_item_t rand_item(int cv_pct, int cl_pct, int sv_pct);
    return mk($urandom_range(99) < cv_pct, 1'($urandom_range(1)),
              $urandom_range(99) < cl_pct, $urandom_range(99) < sv_pct,
              NUM_LINES'($urandom_range(15)));
  endfunction

  task automatic drive_fields(corr_item_t it);
    code_valid       = it.code_valid;
    code_bit         = it.code_bit;
    code_last        = it.code_last;
    sample_valid     = it.sample_valid;
    bit_n_inphase    = it.smp[LINE_NI];
    bit_n_quadrature = it.smp[LINE_NQ];
    bit_p_inphase    = it.smp[LINE_PI];
    bit_p_quadrature = it.smp[LINE_PQ];
  endtask

  task automatic idle_gap(int n);
    repeat (n) begin
      @(negedge clk);
      in_valid = 1'b0;
      drive_fields(rand_item(50, 50, 50));
    end
  endtask

  task automatic send_item(corr_item_t it);
    @(negedge clk);
    in_valid = 1'b1;
    drive_fields(it);
    do @(posedge clk); while (in_stall);
    sb.correlate_item(it);
    n_items++;
    if (it.sample_valid) n_samples++;
    if (!steady && $urandom_range(99) < 20) idle_gap($urandom_range(1, 2));
  endtask

  // pause input until every expected bin is out and the front end has settled
  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (sb.expected_bins.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_mode(bit [1:0] m);
    drain();
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data  = m;
    do @(posedge clk); while (!cfg_ready);
    sb.group_mode = m;
    n_cfg++;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // receiver: random stalls, one long hold-off on request
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        out_stall = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        out_stall = steady ? 1'b0 : ($urandom_range(99) < 20);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check_bin('{frame_kind, bin_index, real_part, imag_part, frame_end, run_end});
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    wait (rst === 1'b0);
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("watchdog: no item moved for %0d cycles", STALL_LIMIT);
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    corr_item_t it;
    int m;
    bit chip;
    sb        = new();
    rst       = 1'b1;
    in_valid  = 1'b0;
    cfg_valid = 1'b0;
    cfg_data  = MODE_SINGLE;
    steady    = 1'b0;
    hold_req  = 1'b0;
    hold_done = 1'b0;
    n_items   = 0;
    n_samples = 0;
    n_cfg     = 0;
    drive_fields(mk(0, 0, 0, 0, '0));
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed
    send_item(mk(0, 0, 0, 1, 4'b0000));
    send_item(mk(0, 0, 0, 1, 4'b1111));
    send_item(mk(1, 1, 0, 0, 4'b0000));
    send_item(mk(1, 1, 1, 0, 4'b0000));
    send_item(mk(1, 0, 1, 1, 4'b1010));
    send_item(mk(0, 1, 0, 1, 4'b0101));
    send_item(mk(0, 1, 1, 1, 4'b0011));
    send_item(mk(0, 1, 0, 0, 4'b1111));
    write_mode(MODE_PAIR);
    repeat (3) send_item(rand_item(80, 30, 100));
    write_mode(MODE_QUAD);
    repeat (3) send_item(rand_item(80, 30, 100));
    write_mode(MODE_QUAD_B);
    repeat (3) send_item(rand_item(80, 30, 100));
    write_mode(MODE_SINGLE);
    repeat (2) send_item(rand_item(80, 30, 100));

    // random code loading and samples
    write_mode(2'($urandom_range(0, 3)));
    repeat (45) send_item(rand_item(75, 8, 70));
    send_item(mk(1, 1'($urandom_range(1)), 1, 1, NUM_LINES'($urandom_range(15))));

    // samples that line up with the active code in the upper sections
    write_mode(MODE_SINGLE);
    steady = 1'b1;
    for (int k = 0; k < MATCH_LEN; k++) begin
      m    = LINE_LEN - MATCH_LEN + k;
      chip = sb.code_active[m / 2];
      it   = rand_item(50, 0, 100);
      it.smp[LINE_NI] = chip;
      it.smp[LINE_NQ] = ~chip;
      it.smp[LINE_PI] = chip;
      it.smp[LINE_PQ] = ($urandom_range(7) == 0) ? ~chip : chip;
      send_item(it);
    end
    steady = 1'b0;

    // output hold-off while input keeps coming
    write_mode(MODE_QUAD_B);
    hold_req = 1'b1;
    repeat (45) send_item(rand_item(75, 8, 70));

    drain();
    repeat (20) @(posedge clk);
    $display("run: %0d items (%0d with samples), %0d bins checked, %0d mode writes",
             n_items, n_samples, sb.checked, n_cfg);
    $display("run: all group modes, code reloads, a matched code run and a long output hold-off");
    if (sb.mismatches == 0 && sb.expected_bins.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("mismatches: %0d, bins still expected: %0d",
               sb.mismatches, sb.expected_bins.size());
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: files.f
hdl/qccc_pkg.sv
hdl/qccc_front.sv
hdl/qccc_queue.sv
hdl/qccc_back.sv
hdl/quad_channel_code_correlator.sv
tb/testbench.sv
